FILE: design/greedy_gated_nearest_match_defines.svh
// assertion macros shared by the nearest-match design files
// used only through `include; needs aclk and aresetn in the including scope
`ifndef GREEDY_GATED_NEAREST_MATCH_DEFINES_SVH
`define GREEDY_GATED_NEAREST_MATCH_DEFINES_SVH

`ifndef SYNTHESIS

`define GNM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define GNM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define GNM_ASSERT(lbl, prop, msg)

`define GNM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/gnm_pkg.sv
`timescale 1ns / 1ps
// types and codes for the greedy gated nearest-match block
// no dependencies
package gnm_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_ASSOC  = 2'd2;

    localparam logic [1:0] OUT_MATCHED = 2'd0;
    localparam logic [1:0] OUT_NEW     = 2'd1;
    localparam logic [1:0] OUT_INVALID = 2'd2;

    localparam logic [14:0] GATE_RESET = 15'd256;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               obs_valid;
        logic               last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] assigned_id;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } centre_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

endpackage

FILE: design/greedy_gated_nearest_match.sv
`timescale 1ns / 1ps
// Greedy gated nearest-match of observation centres against a table of object centres.
// Clear and append items complete when accepted. An associate item with a valid observation
// scans the N stored objects: the centre memory is read one entry per
// cycle through its single read port, each entry passes a four-stage squared-distance
// pipeline, and a decide state then updates the taken marks and instance counter.
// Invalid observations and an empty table skip the scan and go straight to decide.
// A finished result sits in the output register while the block takes the next item.
// The centre memory has no clearing pass; only entries below the object count are read.
// depends on gnm_pkg and greedy_gated_nearest_match_defines.svh
`include "greedy_gated_nearest_match_defines.svh"

module greedy_gated_nearest_match
    import gnm_pkg::*;
#(
    parameter int MAX_OBJECTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        logic [16:0] n;
        d = {a[15], a} - {b[15], b};
        n = ~d + 17'd1;
        return d[16] ? n[15:0] : d[15:0];
    endfunction

    centre_t mem [MAX_OBJECTS];
    centre_t rd_data_reg;

    state_t state_reg, state_next;

    logic [14:0]            gate_reg;
    logic [29:0]            gate_sq_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [MAX_OBJECTS-1:0] taken_reg;
    logic [15:0]            inst_cnt_reg;

    centre_t                obs_reg;
    logic                   obs_valid_reg;
    logic                   obs_last_reg;

    logic [IDX_W-1:0]       rd_idx_reg;

    logic                   p1_v_reg;
    logic [IDX_W-1:0]       p1_idx_reg;
    logic                   p2_v_reg;
    logic [IDX_W-1:0]       p2_idx_reg;
    logic                   p2_taken_reg;
    logic [15:0]            p2_dx_reg, p2_dy_reg, p2_dz_reg;
    logic                   p3_v_reg;
    logic [IDX_W-1:0]       p3_idx_reg;
    logic                   p3_taken_reg;
    logic [31:0]            p3_sx_reg, p3_sy_reg, p3_sz_reg;
    logic                   p4_v_reg;
    logic [IDX_W-1:0]       p4_idx_reg;
    logic                   p4_taken_reg;
    logic [33:0]            p4_d_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [33:0]            best_d_reg;

    logic                   m_valid_reg;
    out_item_t              m_item_reg;

    logic                   in_xfer;
    logic                   scan_en;
    logic                   scan_last;
    logic                   pipe_busy;
    logic                   out_free;
    logic                   decide_fire;
    logic                   matched;

    assign in_xfer   = s_valid && s_ready;
    assign scan_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == total_reg;
    assign pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign matched   = obs_valid_reg && found_reg && (best_d_reg < {4'd0, gate_sq_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer && s_item.operation == OP_ASSOC) begin
                    if (!s_item.obs_valid || total_reg == '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        scan_en     = 1'b0;
        decide_fire = 1'b0;
        case (state_reg)
            S_IDLE:   s_ready = 1'b1;
            S_SCAN:   scan_en = 1'b1;
            S_DRAIN:  ;
            S_DECIDE: decide_fire = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // centre memory
    always_ff @(posedge aclk) begin
        if (in_xfer && s_item.operation == OP_APPEND && total_reg < CNT_W'(MAX_OBJECTS)) begin
            mem[total_reg[IDX_W-1:0]] <= '{x: s_item.pos_x, y: s_item.pos_y, z: s_item.pos_z};
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    // configuration and gate square
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= GATE_RESET;
        end else if (cfg_wr_en) begin
            gate_reg <= cfg_wr_data;
        end
        gate_sq_reg <= 30'(gate_reg) * 30'(gate_reg);
    end

    // table count, taken marks, instance counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            taken_reg    <= '0;
            inst_cnt_reg <= '0;
        end else begin
            if (in_xfer && s_item.operation == OP_CLEAR) begin
                total_reg <= '0;
                taken_reg <= '0;
            end else if (in_xfer && s_item.operation == OP_APPEND
                         && total_reg < CNT_W'(MAX_OBJECTS)) begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (decide_fire) begin
                if (obs_last_reg) begin
                    taken_reg <= '0;
                end else if (matched) begin
                    taken_reg[best_idx_reg] <= 1'b1;
                end
                if (obs_valid_reg && !matched) begin
                    inst_cnt_reg <= inst_cnt_reg + 16'd1;
                end
            end
        end
    end

    // observation capture and scan address
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            obs_reg       <= '{x: s_item.pos_x, y: s_item.pos_y, z: s_item.pos_z};
            obs_valid_reg <= s_item.obs_valid;
            obs_last_reg  <= s_item.last_in_frame;
        end
        if (in_xfer) begin
            rd_idx_reg <= '0;
        end else if (scan_en) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // distance pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= scan_en;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
        p1_idx_reg   <= rd_idx_reg;
        p2_idx_reg   <= p1_idx_reg;
        p2_taken_reg <= taken_reg[p1_idx_reg];
        p2_dx_reg    <= abs_diff(obs_reg.x, rd_data_reg.x);
        p2_dy_reg    <= abs_diff(obs_reg.y, rd_data_reg.y);
        p2_dz_reg    <= abs_diff(obs_reg.z, rd_data_reg.z);
        p3_idx_reg   <= p2_idx_reg;
        p3_taken_reg <= p2_taken_reg;
        p3_sx_reg    <= 32'(p2_dx_reg) * 32'(p2_dx_reg);
        p3_sy_reg    <= 32'(p2_dy_reg) * 32'(p2_dy_reg);
        p3_sz_reg    <= 32'(p2_dz_reg) * 32'(p2_dz_reg);
        p4_idx_reg   <= p3_idx_reg;
        p4_taken_reg <= p3_taken_reg;
        p4_d_reg     <= 34'(p3_sx_reg) + 34'(p3_sy_reg) + 34'(p3_sz_reg);
    end

    // running best, lowest index kept on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (in_xfer) begin
            found_reg <= 1'b0;
        end else if (p4_v_reg && !p4_taken_reg && (!found_reg || p4_d_reg < best_d_reg)) begin
            found_reg <= 1'b1;
        end
        if (p4_v_reg && !p4_taken_reg && (!found_reg || p4_d_reg < best_d_reg)) begin
            best_idx_reg <= p4_idx_reg;
            best_d_reg   <= p4_d_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (decide_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (decide_fire) begin
            if (!obs_valid_reg) begin
                m_item_reg <= '{outcome: OUT_INVALID, assigned_id: 16'd0};
            end else if (matched) begin
                m_item_reg <= '{outcome: OUT_MATCHED, assigned_id: 16'(best_idx_reg)};
            end else begin
                m_item_reg <= '{outcome: OUT_NEW, assigned_id: inst_cnt_reg};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `GNM_ASSERT(a_scan_in_table, scan_en |-> (CNT_W'(rd_idx_reg) < total_reg), "scan past table end")
    `GNM_ASSERT(a_match_untaken, (decide_fire && matched) |-> !taken_reg[best_idx_reg], "matched a taken object")
    `GNM_ASSERT(a_idle_pipe_empty, s_ready |-> !pipe_busy, "input taken with scan in flight")
    `GNM_ASSERT(a_counter_step, (decide_fire && obs_valid_reg && !matched) |=> (inst_cnt_reg == $past(inst_cnt_reg) + 16'd1), "instance counter did not advance")
    `GNM_ASSERT_ALWAYS(a_result_from_decide, $rose(m_valid_reg) |-> ($past(state_reg) == S_DECIDE), "result without decision")

endmodule
